/* rtl/core/dlcs_pkg.sv */
// Shared types, codes and defaults for the diagnostic link connection sequencer.
package dlcs_pkg;

   // Field and register widths
   localparam int FUNC_W           = 2;
   localparam int CODE_W           = 8;
   localparam int CFG_W            = 16;
   localparam int LINK_W           = 3;
   localparam int CAUSE_W          = 3;
   localparam int CSR_INDEX_W      = 3;
   localparam int REQ_TDATA_W      = 16;
   localparam int RSP_TDATA_W      = 16;
   localparam int ELAPSED_BITS_DEF = 16;

   // Item kinds
   localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_UP       = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ERROR    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_RESPONSE = 2'd3;

   // Link state codes as reported
   localparam logic [LINK_W-1:0] LINK_IDLE       = 3'd0;
   localparam logic [LINK_W-1:0] LINK_CONNECTING = 3'd1;
   localparam logic [LINK_W-1:0] LINK_CONNECTED  = 3'd2;
   localparam logic [LINK_W-1:0] LINK_ACTIVE     = 3'd3;
   localparam logic [LINK_W-1:0] LINK_ERROR      = 3'd4;

   // Teardown causes
   localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 3'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_EVENT   = 3'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_CONNECT = 3'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_ROUTING = 3'd3;
   localparam logic [CAUSE_W-1:0] CAUSE_STATE   = 3'd4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RECONNECT_INTERVAL = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONNECT_TIMEOUT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUTING_DELAY      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUTING_TIMEOUT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUCCESS_CODE       = 3'd4;

   // Register reset values
   localparam logic [CFG_W-1:0]  RECONNECT_INTERVAL_RST = 16'd1000;
   localparam logic [CFG_W-1:0]  CONNECT_TIMEOUT_RST    = 16'd5000;
   localparam logic [CFG_W-1:0]  ROUTING_DELAY_RST      = 16'd200;
   localparam logic [CFG_W-1:0]  ROUTING_TIMEOUT_RST    = 16'd2000;
   localparam logic [CODE_W-1:0] SUCCESS_CODE_RST       = 8'd16;

   typedef enum logic [4:0] {
      ST_IDLE       = 5'b00001,
      ST_CONNECTING = 5'b00010,
      ST_CONNECTED  = 5'b00100,
      ST_ACTIVE     = 5'b01000,
      ST_ERROR      = 5'b10000
   } state_type;

   typedef struct packed {
      logic [CFG_W-1:0]  reconnect_interval_ms;
      logic [CFG_W-1:0]  connect_timeout_ms;
      logic [CFG_W-1:0]  routing_delay_ms;
      logic [CFG_W-1:0]  routing_timeout_ms;
      logic [CODE_W-1:0] success_code;
   } cfg_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              open_ok;
      logic              send_ok;
      logic              response_valid;
      logic [CODE_W-1:0] answer_code;
   } item_type;

   typedef struct packed {
      logic [LINK_W-1:0]  link_state;
      logic               start_connect;
      logic               send_routing_request;
      logic               teardown;
      logic [CAUSE_W-1:0] teardown_cause;
   } result_type;

   function automatic logic [LINK_W-1:0] link_code(state_type st);
      logic [LINK_W-1:0] code;
      case (st)
         ST_IDLE:       code = LINK_IDLE;
         ST_CONNECTING: code = LINK_CONNECTING;
         ST_CONNECTED:  code = LINK_CONNECTED;
         ST_ACTIVE:     code = LINK_ACTIVE;
         default:       code = LINK_ERROR;
      endcase
      return code;
   endfunction

endpackage

/* rtl/core/diag_link_connection_sequencer_unit.sv */
// Top level of the diagnostic link connection sequencer: channels, beat registers, checks.
//
// Usage
//   req_ carries one beat per event: a one millisecond tick, a link-up, a link-error
//   or a routing activation response, with the kind in req_tuser. Every request beat
//   gives exactly one response beat on rsp_, carrying the link state after the beat
//   and, for ticks, the connect, routing request and teardown flags with the cause.
//   csr_ writes the five timing and code registers; write them only while no beat
//   is in flight. csr_ready is always high.
// Flow and throughput
//   A request beat lands in the input register and is stepped through the sequencer
//   logic into the result register, shown on rsp_, once that register is free or
//   being emptied. One beat per cycle is sustained while rsp_tready is high, set by
//   the single pass from input register through step logic into the result register.
// Reset
//   Synchronous reset empties both beat registers, puts the link in idle, clears
//   the pending flags and the elapsed counters, and loads the register defaults.
// Stall
//   When rsp_tready is low the result register holds; the input register still
//   takes one more beat, after which req_tready drops until the result is taken.
module diag_link_connection_sequencer_unit #(
   parameter int ELAPSED_BITS = dlcs_pkg::ELAPSED_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // open_ok[0], send_ok[1], response_valid[2], answer_code[10:3], zero[15:11]
   input  logic [dlcs_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // func[1:0]
   input  logic [dlcs_pkg::FUNC_W-1:0]          req_tuser,
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // link_state[2:0], start_connect[3], send_routing_request[4], teardown[5],
   // teardown_cause[8:6], zero[15:9]
   output logic [dlcs_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dlcs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dlcs_pkg::CFG_W-1:0]           csr_wdata
);

   dlcs_pkg::cfg_type    cfg;
   dlcs_pkg::item_type   item_ff;
   dlcs_pkg::result_type step_result;
   dlcs_pkg::result_type result_ff;
   logic                 in_valid_ff;
   logic                 out_valid_ff;
   logic                 advance;
   logic                 req_take;

   // Step the held beat once the result register is free or being emptied
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   dlcs_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   dlcs_core #(
      .ELAPSED_BITS (ELAPSED_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   // Input beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.func           <= req_tuser;
         item_ff.open_ok        <= req_tdata[0];
         item_ff.send_ok        <= req_tdata[1];
         item_ff.response_valid <= req_tdata[2];
         item_ff.answer_code    <= req_tdata[10:3];
      end
   end

   // Result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, result_ff.teardown_cause, result_ff.teardown,
                        result_ff.send_routing_request, result_ff.start_connect,
                        result_ff.link_state};

   // A stepped beat is always shown on the next cycle
   a_step_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("stepped beat not presented");

   // Teardown always reports a cause and leaves the link idle
   a_teardown_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && result_ff.teardown) |->
         (result_ff.teardown_cause != dlcs_pkg::CAUSE_NONE &&
          result_ff.link_state == dlcs_pkg::LINK_IDLE))
      else $error("teardown without cause or not idle");

   // A started attempt leaves the link connecting and never coincides with teardown
   a_start_connecting: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && result_ff.start_connect) |->
         (result_ff.link_state == dlcs_pkg::LINK_CONNECTING && !result_ff.teardown))
      else $error("connection start with wrong state");

   // A held beat that cannot advance keeps the request side closed
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while input register is blocked");

endmodule

/* rtl/core/dlcs_csr.sv */
// Configuration register file for the link sequencer.
module dlcs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [dlcs_pkg::CSR_INDEX_W-1:0]   wr_index,
   input  logic [dlcs_pkg::CFG_W-1:0]         wr_data,
   output dlcs_pkg::cfg_type                  cfg
);

   dlcs_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reconnect_interval_ms <= dlcs_pkg::RECONNECT_INTERVAL_RST;
         cfg_ff.connect_timeout_ms    <= dlcs_pkg::CONNECT_TIMEOUT_RST;
         cfg_ff.routing_delay_ms      <= dlcs_pkg::ROUTING_DELAY_RST;
         cfg_ff.routing_timeout_ms    <= dlcs_pkg::ROUTING_TIMEOUT_RST;
         cfg_ff.success_code          <= dlcs_pkg::SUCCESS_CODE_RST;
      end else if (wr_en) begin
         case (wr_index)
            dlcs_pkg::CSR_RECONNECT_INTERVAL: cfg_ff.reconnect_interval_ms <= wr_data;
            dlcs_pkg::CSR_CONNECT_TIMEOUT:    cfg_ff.connect_timeout_ms    <= wr_data;
            dlcs_pkg::CSR_ROUTING_DELAY:      cfg_ff.routing_delay_ms      <= wr_data;
            dlcs_pkg::CSR_ROUTING_TIMEOUT:    cfg_ff.routing_timeout_ms    <= wr_data;
            dlcs_pkg::CSR_SUCCESS_CODE:
               cfg_ff.success_code <= wr_data[dlcs_pkg::CODE_W-1:0];
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/dlcs_core.sv */
// Link state, pending flags, elapsed counters and the per-beat step logic.
module dlcs_core #(
   parameter int ELAPSED_BITS = dlcs_pkg::ELAPSED_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  dlcs_pkg::item_type     item,
   input  dlcs_pkg::cfg_type      cfg,
   output dlcs_pkg::result_type   result
);

   localparam int CMP_W = (ELAPSED_BITS > dlcs_pkg::CFG_W) ? ELAPSED_BITS : dlcs_pkg::CFG_W;

   typedef logic [ELAPSED_BITS-1:0] elapsed_type;

   dlcs_pkg::state_type state_ff, state_in;
   logic                up_ff, up_in;
   logic                err_ff, err_in;
   logic                rq_ff, rq_in;
   elapsed_type         since_reconnect_ff, since_reconnect_in;
   elapsed_type         since_connect_ff, since_connect_in;
   elapsed_type         since_up_ff, since_up_in;
   elapsed_type         since_request_ff, since_request_in;

   logic                       started, sent, torn;
   logic [dlcs_pkg::CAUSE_W-1:0] cause;

   function automatic elapsed_type sat_inc(elapsed_type v);
      return (v == '1) ? v : v + elapsed_type'(1);
   endfunction

   function automatic logic reached(elapsed_type cnt, logic [dlcs_pkg::CFG_W-1:0] limit);
      return CMP_W'(cnt) >= CMP_W'(limit);
   endfunction

   always_comb begin
      state_in           = state_ff;
      up_in              = up_ff;
      err_in             = err_ff;
      rq_in              = rq_ff;
      since_reconnect_in = since_reconnect_ff;
      since_connect_in   = since_connect_ff;
      since_up_in        = since_up_ff;
      since_request_in   = since_request_ff;
      started            = 1'b0;
      sent               = 1'b0;
      torn               = 1'b0;
      cause              = dlcs_pkg::CAUSE_NONE;

      case (item.func)
         dlcs_pkg::FUNC_UP:    up_in  = 1'b1;
         dlcs_pkg::FUNC_ERROR: err_in = 1'b1;
         dlcs_pkg::FUNC_RESPONSE: begin
            if (item.response_valid && (state_ff == dlcs_pkg::ST_CONNECTING ||
                                        state_ff == dlcs_pkg::ST_CONNECTED ||
                                        state_ff == dlcs_pkg::ST_ACTIVE)) begin
               if (item.answer_code == cfg.success_code) state_in = dlcs_pkg::ST_ACTIVE;
               else err_in = 1'b1;
            end
         end
         dlcs_pkg::FUNC_TICK: begin
            since_reconnect_in = sat_inc(since_reconnect_ff);
            since_connect_in   = sat_inc(since_connect_ff);
            since_up_in        = sat_inc(since_up_ff);
            since_request_in   = sat_inc(since_request_ff);

            if (up_ff) begin
               up_in       = 1'b0;
               state_in    = dlcs_pkg::ST_CONNECTED;
               since_up_in = '0;
               rq_in       = 1'b1;
            end

            if (err_ff) begin
               torn  = 1'b1;
               cause = dlcs_pkg::CAUSE_EVENT;
            end else begin
               case (state_in)
                  dlcs_pkg::ST_IDLE: begin
                     if (reached(since_reconnect_in, cfg.reconnect_interval_ms)) begin
                        if (item.open_ok) begin
                           state_in         = dlcs_pkg::ST_CONNECTING;
                           since_connect_in = '0;
                           up_in            = 1'b0;
                           err_in           = 1'b0;
                           started          = 1'b1;
                        end else begin
                           state_in = dlcs_pkg::ST_ERROR;
                        end
                        since_reconnect_in = '0;
                     end
                  end
                  dlcs_pkg::ST_CONNECTING: begin
                     if (reached(since_connect_in, cfg.connect_timeout_ms)) begin
                        torn  = 1'b1;
                        cause = dlcs_pkg::CAUSE_CONNECT;
                     end
                  end
                  dlcs_pkg::ST_CONNECTED: begin
                     if (rq_in && reached(since_up_in, cfg.routing_delay_ms)) begin
                        rq_in = 1'b0;
                        if (item.send_ok) begin
                           since_request_in = '0;
                           sent             = 1'b1;
                        end else begin
                           err_in = 1'b1;
                        end
                     end
                     if (!rq_in && reached(since_request_in, cfg.routing_timeout_ms)) begin
                        torn  = 1'b1;
                        cause = dlcs_pkg::CAUSE_ROUTING;
                     end
                  end
                  dlcs_pkg::ST_ACTIVE: ;
                  dlcs_pkg::ST_ERROR: begin
                     torn  = 1'b1;
                     cause = dlcs_pkg::CAUSE_STATE;
                  end
                  default: begin
                     torn  = 1'b1;
                     cause = dlcs_pkg::CAUSE_STATE;
                  end
               endcase
            end

            // drop the link back to idle
            if (torn) begin
               up_in              = 1'b0;
               err_in             = 1'b0;
               rq_in              = 1'b0;
               state_in           = dlcs_pkg::ST_IDLE;
               since_reconnect_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= dlcs_pkg::ST_IDLE;
         up_ff              <= 1'b0;
         err_ff             <= 1'b0;
         rq_ff              <= 1'b0;
         since_reconnect_ff <= '0;
         since_connect_ff   <= '0;
         since_up_ff        <= '0;
         since_request_ff   <= '0;
      end else if (step) begin
         state_ff           <= state_in;
         up_ff              <= up_in;
         err_ff             <= err_in;
         rq_ff              <= rq_in;
         since_reconnect_ff <= since_reconnect_in;
         since_connect_ff   <= since_connect_in;
         since_up_ff        <= since_up_in;
         since_request_ff   <= since_request_in;
      end
   end

   assign result.link_state           = dlcs_pkg::link_code(state_in);
   assign result.start_connect        = started;
   assign result.send_routing_request = sent;
   assign result.teardown             = torn;
   assign result.teardown_cause       = cause;

endmodule
